// ----- hdl/vfss_pkg.sv -----
// ----------------------------------------------------------------------------
// vfss_pkg
// Shared types, widths and codes of the versioned file set selector.
// ----------------------------------------------------------------------------
package vfss_pkg;

	// table sizes and stored length width
	localparam int SNAP_DEPTH  = 16;
	localparam int DELTA_DEPTH = 32;
	localparam int LENGTH_BITS = 48;

	// fixed field widths
	localparam int OP_W     = 2;
	localparam int VER_W    = 63;
	localparam int LEN_W    = 48;
	localparam int STAT_W   = 2;
	localparam int KIND_W   = 2;
	localparam int IDX_W    = 5;
	localparam int BYTES_W  = 53;
	localparam int INCL_W   = 64;

	// derived widths
	localparam int LEN_KEEP = (LENGTH_BITS < LEN_W) ? LENGTH_BITS : LEN_W;
	localparam int REC_W    = VER_W + LEN_KEEP;
	localparam int SA_W     = (SNAP_DEPTH > 1) ? $clog2(SNAP_DEPTH) : 1;
	localparam int DA_W     = (DELTA_DEPTH > 1) ? $clog2(DELTA_DEPTH) : 1;
	localparam int SC_W     = $clog2(SNAP_DEPTH + 1);
	localparam int DC_W     = $clog2(DELTA_DEPTH + 1);
	localparam int SCAN_W   = (SC_W > DC_W) ? SC_W : DC_W;
	localparam int SUM_W    = LEN_KEEP + DC_W;

	// operation codes
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
	localparam logic [OP_W-1:0] OP_SNAP  = 2'd1;
	localparam logic [OP_W-1:0] OP_DELTA = 2'd2;
	localparam logic [OP_W-1:0] OP_QUERY = 2'd3;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
	localparam logic [STAT_W-1:0] ST_ORDER  = 2'd2;
	localparam logic [STAT_W-1:0] ST_NOSNAP = 2'd3;

	// file kind codes
	localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SNAP  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DELTA = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [VER_W-1:0] file_version;
		logic [LEN_W-1:0] file_length;
		logic [VER_W-1:0] begin_version;
		logic [VER_W-1:0] read_version;
		logic             can_collapse;
		logic             summarize;
	} in_payload_t;

	typedef struct packed {
		logic [STAT_W-1:0]        status;
		logic [KIND_W-1:0]        file_kind;
		logic [IDX_W-1:0]         file_index;
		logic [VER_W-1:0]         selected_version;
		logic [LEN_W-1:0]         selected_length;
		logic [BYTES_W-1:0]       delta_bytes;
		logic signed [INCL_W-1:0] included_version;
		logic                     last;
	} out_payload_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic snap_start;
		logic delta_start;
		logic scan_snap;
		logic scan_delta;
		logic pend_nosnap;
		logic finish;
		logic emit_snap;
		logic emit_rd;
		logic emit_wr;
		logic load_single;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic in_query;
		logic need_snap;
		logic scan_done;
		logic have_snap;
		logic empty;
		logic last_delta;
		logic out_free;
	} dp_stat_t;

endpackage

// ----- hdl/vfss_if.sv -----
// ----------------------------------------------------------------------------
// vfss_in_if / vfss_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface vfss_in_if import vfss_pkg::*; ();
	logic        valid;
	logic        ready;
	in_payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface vfss_out_if import vfss_pkg::*; ();
	logic         valid;
	logic         ready;
	out_payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/versioned_file_set_selector_core.sv -----
// ----------------------------------------------------------------------------
// versioned_file_set_selector_core
// Keeps snapshot and delta file tables and selects the files for a read.
// ----------------------------------------------------------------------------
// usage
//   req carries one command per transfer: clear, append snapshot, append
//   delta or query. rsp returns the results; last marks the final result
//   of a command. Clear and append give one result, a query gives the chosen
//   snapshot and then the chosen deltas, or one status result.
// sequence
//   clear and append: accepted in S_IDLE, result loaded from S_ONE once
//   the output register is free. A new command is taken only in S_IDLE.
//   query: a setup state, a snapshot search (when a snapshot is needed),
//   a delta count pass, the finish and decide selection states, then the
//   snapshot result and a read and a write state for each delta result.
//   Each table memory has one read port, one entry a cycle.
// reset
//   both tables are empty after reset; table contents are not cleared.
// stalls
//   a waiting result is held in the output register; the next command is
//   accepted while it waits, and emission pauses until rsp is taken.
// ----------------------------------------------------------------------------
module versioned_file_set_selector_core import vfss_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	vfss_in_if.sink    req,
	vfss_out_if.source rsp
);

	ctrl_cmd_t    cmd;
	dp_stat_t     stat;
	logic         in_ready;
	logic         out_valid;
	out_payload_t out_data;

	vfss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	vfss_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (req.data),
		.out_valid (out_valid),
		.out_data  (out_data),
		.out_ready (rsp.ready)
	);

	assign req.ready = in_ready;
	assign rsp.valid = out_valid;
	assign rsp.data  = out_data;

endmodule

// ----- hdl/vfss_ram.sv -----
// ----------------------------------------------------------------------------
// vfss_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module vfss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port, holds when idle
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hdl/vfss_ctrl.sv -----
// ----------------------------------------------------------------------------
// vfss_ctrl
// Sequencer of the selector: accept, table scans, selection and emission.
// ----------------------------------------------------------------------------
module vfss_ctrl import vfss_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_QSTART = 4'd1;
	localparam logic [3:0] S_SSCAN  = 4'd2;
	localparam logic [3:0] S_DSCAN  = 4'd3;
	localparam logic [3:0] S_FIN    = 4'd4;
	localparam logic [3:0] S_DECIDE = 4'd5;
	localparam logic [3:0] S_ESNAP  = 4'd6;
	localparam logic [3:0] S_ERD    = 4'd7;
	localparam logic [3:0] S_EWR    = 4'd8;
	localparam logic [3:0] S_ONE    = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = stat.in_query ? S_QSTART : S_ONE;
				end
			end
			S_QSTART: begin
				if (stat.need_snap) begin
					cmd.snap_start = 1'b1;
					state_d        = S_SSCAN;
				end else begin
					cmd.delta_start = 1'b1;
					state_d         = S_DSCAN;
				end
			end
			S_SSCAN: begin
				cmd.scan_snap = 1'b1;
				if (stat.scan_done) begin
					if (stat.have_snap) begin
						cmd.delta_start = 1'b1;
						state_d         = S_DSCAN;
					end else begin
						cmd.pend_nosnap = 1'b1;
						state_d         = S_ONE;
					end
				end
			end
			S_DSCAN: begin
				cmd.scan_delta = 1'b1;
				if (stat.scan_done) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				cmd.finish = 1'b1;
				state_d    = S_DECIDE;
			end
			S_DECIDE: begin
				if (stat.have_snap) begin
					state_d = S_ESNAP;
				end else if (stat.empty) begin
					state_d = S_ONE;
				end else begin
					state_d = S_ERD;
				end
			end
			S_ESNAP: begin
				if (stat.out_free) begin
					cmd.emit_snap = 1'b1;
					state_d       = stat.empty ? S_IDLE : S_ERD;
				end
			end
			S_ERD: begin
				cmd.emit_rd = 1'b1;
				state_d     = S_EWR;
			end
			S_EWR: begin
				if (stat.out_free) begin
					cmd.emit_wr = 1'b1;
					state_d     = stat.last_delta ? S_IDLE : S_ERD;
				end
			end
			S_ONE: begin
				if (stat.out_free) begin
					cmd.load_single = 1'b1;
					state_d         = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- hdl/vfss_dp.sv -----
// ----------------------------------------------------------------------------
// vfss_dp
// Datapath: file tables, append checks, scan counters, selection and result
// register.
// ----------------------------------------------------------------------------
module vfss_dp import vfss_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  ctrl_cmd_t    cmd,
	output dp_stat_t     stat,
	input  in_payload_t  in_data,
	output logic         out_valid,
	output out_payload_t out_data,
	input  logic         out_ready
);

	// latched query fields
	logic [VER_W-1:0] begin_q;
	logic [VER_W-1:0] rd_q;
	logic             coll_q;
	logic             summ_q;

	// table bookkeeping
	logic [SC_W-1:0]  snap_count_q;
	logic [DC_W-1:0]  delta_count_q;
	logic [VER_W-1:0] snap_last_q;
	logic [VER_W-1:0] delta_last_q;

	// pending single result
	logic [STAT_W-1:0] pend_status_q;
	logic [KIND_W-1:0] pend_kind_q;
	logic [IDX_W-1:0]  pend_idx_q;
	logic [VER_W-1:0]  pend_ver_q;
	logic [LEN_W-1:0]  pend_len_q;

	// scan engine
	logic [SCAN_W-1:0] scan_addr_q;
	logic [SCAN_W-1:0] scan_lim;
	logic              scan_go;
	logic              rv_s1;

	// selection state
	logic                have_snap_q;
	logic [SA_W-1:0]     s_idx_q;
	logic [VER_W-1:0]    s_ver_q;
	logic [LEN_KEEP-1:0] s_len_q;
	logic [DC_W-1:0]     n_lt_begin_q;
	logic [DC_W-1:0]     n_le_sver_q;
	logic [DC_W-1:0]     n_lt_rd_q;
	logic [DC_W-1:0]     n_le_rd_q;
	logic [SUM_W-1:0]    sum_q;
	logic [DC_W-1:0]     cur_q;
	logic [DC_W-1:0]     end_q;
	logic [SUM_W-1:0]    bytes_q;
	logic                out_valid_q;

	// memory ports
	logic [REC_W-1:0]    snap_rdata;
	logic [REC_W-1:0]    delta_rdata;
	logic [REC_W-1:0]    wrec;
	logic                snap_we;
	logic                delta_we;
	logic                snap_re;
	logic                delta_re;
	logic [DA_W-1:0]     delta_raddr;
	logic [VER_W-1:0]    s_rd_ver;
	logic [VER_W-1:0]    d_rd_ver;
	logic [LEN_KEEP-1:0] d_rd_len;
	logic [LEN_KEEP-1:0] s_rd_len;

	// append checks
	logic snap_full;
	logic snap_bad;
	logic delta_full;
	logic delta_bad;
	logic need_snap;
	logic out_free;

	// selection logic
	logic             coll_fail;
	logic             hs_sel;
	logic [DC_W-1:0]  d_sel;
	logic [DC_W-1:0]  t_sel;
	logic             trail;
	logic [SUM_W-1:0] bytes_next;

	assign need_snap  = (begin_q == '0) || coll_q;
	assign out_free   = !out_valid_q || out_ready;
	assign snap_full  = (snap_count_q == SC_W'(SNAP_DEPTH));
	assign snap_bad   = (snap_count_q != '0) && (snap_last_q >= in_data.file_version);
	assign delta_full = (delta_count_q == DC_W'(DELTA_DEPTH));
	assign delta_bad  = (delta_count_q != '0) && (delta_last_q >= in_data.file_version);
	assign wrec       = {in_data.file_version, in_data.file_length[LEN_KEEP-1:0]};
	assign snap_we    = cmd.accept && (in_data.op == OP_SNAP) && !snap_full && !snap_bad;
	assign delta_we   = cmd.accept && (in_data.op == OP_DELTA) && !delta_full && !delta_bad;

	// scan addressing
	assign scan_lim    = cmd.scan_snap ? SCAN_W'(snap_count_q) : SCAN_W'(delta_count_q);
	assign scan_go     = (cmd.scan_snap || cmd.scan_delta) && (scan_addr_q < scan_lim);
	assign snap_re     = scan_go && cmd.scan_snap;
	assign delta_re    = (scan_go && cmd.scan_delta) || cmd.emit_rd;
	assign delta_raddr = cmd.emit_rd ? cur_q[DA_W-1:0] : scan_addr_q[DA_W-1:0];

	assign s_rd_ver = snap_rdata[REC_W-1 -: VER_W];
	assign s_rd_len = snap_rdata[LEN_KEEP-1:0];
	assign d_rd_ver = delta_rdata[REC_W-1 -: VER_W];
	assign d_rd_len = delta_rdata[LEN_KEEP-1:0];

	vfss_ram #(.WIDTH(REC_W), .DEPTH(SNAP_DEPTH)) u_snap_ram (
		.clk   (clk),
		.we    (snap_we),
		.waddr (snap_count_q[SA_W-1:0]),
		.wdata (wrec),
		.re    (snap_re),
		.raddr (scan_addr_q[SA_W-1:0]),
		.rdata (snap_rdata)
	);

	vfss_ram #(.WIDTH(REC_W), .DEPTH(DELTA_DEPTH)) u_delta_ram (
		.clk   (clk),
		.we    (delta_we),
		.waddr (delta_count_q[DA_W-1:0]),
		.wdata (wrec),
		.re    (delta_re),
		.raddr (delta_raddr),
		.rdata (delta_rdata)
	);

	// delta range selection from the scan counts
	always_comb begin
		coll_fail = (begin_q != '0) && coll_q && (sum_q < SUM_W'(s_len_q));
		hs_sel    = need_snap && !coll_fail;
		d_sel     = ((begin_q != '0) && !(coll_q && !coll_fail)) ? n_lt_begin_q : n_le_sver_q;
		t_sel     = (d_sel > n_lt_rd_q) ? d_sel : n_lt_rd_q;
		if (t_sel >= delta_count_q) begin
			trail = 1'b0;
		end else if (summ_q) begin
			trail = (t_sel == n_lt_rd_q) && (n_le_rd_q > n_lt_rd_q);
		end else begin
			trail = (t_sel > d_sel) || !hs_sel || (s_ver_q < rd_q);
		end
	end

	assign bytes_next = bytes_q + SUM_W'(d_rd_len);

	// input latch, tables and pending single result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_count_q  <= '0;
			delta_count_q <= '0;
		end else if (cmd.accept) begin
			begin_q       <= in_data.begin_version;
			rd_q          <= in_data.read_version;
			coll_q        <= in_data.can_collapse;
			summ_q        <= in_data.summarize;
			pend_status_q <= ST_OK;
			pend_kind_q   <= KIND_NONE;
			pend_idx_q    <= '0;
			pend_ver_q    <= '0;
			pend_len_q    <= '0;
			case (in_data.op)
				OP_CLEAR: begin
					snap_count_q  <= '0;
					delta_count_q <= '0;
				end
				OP_SNAP: begin
					if (snap_full) begin
						pend_status_q <= ST_FULL;
					end else if (snap_bad) begin
						pend_status_q <= ST_ORDER;
					end else begin
						pend_kind_q  <= KIND_SNAP;
						pend_idx_q   <= IDX_W'(snap_count_q);
						pend_ver_q   <= in_data.file_version;
						pend_len_q   <= LEN_W'(in_data.file_length[LEN_KEEP-1:0]);
						snap_last_q  <= in_data.file_version;
						snap_count_q <= snap_count_q + SC_W'(1);
					end
				end
				OP_DELTA: begin
					if (delta_full) begin
						pend_status_q <= ST_FULL;
					end else if (delta_bad) begin
						pend_status_q <= ST_ORDER;
					end else begin
						pend_kind_q   <= KIND_DELTA;
						pend_idx_q    <= IDX_W'(delta_count_q);
						pend_ver_q    <= in_data.file_version;
						pend_len_q    <= LEN_W'(in_data.file_length[LEN_KEEP-1:0]);
						delta_last_q  <= in_data.file_version;
						delta_count_q <= delta_count_q + DC_W'(1);
					end
				end
				default: begin
				end
			endcase
		end else if (cmd.pend_nosnap) begin
			pend_status_q <= ST_NOSNAP;
		end
	end

	// scan engine, one table entry per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_addr_q <= '0;
			rv_s1       <= 1'b0;
		end else if (cmd.snap_start || cmd.delta_start) begin
			scan_addr_q <= '0;
			rv_s1       <= 1'b0;
		end else begin
			rv_s1 <= scan_go;
			if (scan_go) begin
				scan_addr_q <= scan_addr_q + SCAN_W'(1);
			end
		end
	end

	// scan index registered alongside the read data so the two stay aligned
	logic [SCAN_W-1:0] idx_s1;
	always_ff @(posedge clk) begin
		idx_s1 <= scan_addr_q;
	end

	// snapshot search, delta counts and emission counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_snap_q <= 1'b0;
			s_ver_q     <= '0;
			s_len_q     <= '0;
			s_idx_q     <= '0;
		end else begin
			if (cmd.accept || cmd.snap_start) begin
				have_snap_q <= 1'b0;
			end
			if (cmd.scan_snap && rv_s1 && (s_rd_ver <= rd_q)) begin
				have_snap_q <= 1'b1;
				s_idx_q     <= idx_s1[SA_W-1:0];
				s_ver_q     <= s_rd_ver;
				s_len_q     <= s_rd_len;
			end
			if (cmd.finish) begin
				have_snap_q <= hs_sel;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.delta_start) begin
			n_lt_begin_q <= '0;
			n_le_sver_q  <= '0;
			n_lt_rd_q    <= '0;
			n_le_rd_q    <= '0;
			sum_q        <= '0;
		end else if (cmd.scan_delta && rv_s1) begin
			n_lt_begin_q <= n_lt_begin_q + DC_W'(d_rd_ver < begin_q);
			n_le_sver_q  <= n_le_sver_q + DC_W'(d_rd_ver <= s_ver_q);
			n_lt_rd_q    <= n_lt_rd_q + DC_W'(d_rd_ver < rd_q);
			n_le_rd_q    <= n_le_rd_q + DC_W'(d_rd_ver <= rd_q);
			if ((d_rd_ver >= begin_q) && (d_rd_ver <= s_ver_q)) begin
				sum_q <= sum_q + SUM_W'(d_rd_len);
			end
		end
		if (cmd.finish) begin
			cur_q   <= d_sel;
			end_q   <= t_sel + DC_W'(trail);
			bytes_q <= '0;
		end else if (cmd.emit_wr) begin
			cur_q   <= cur_q + DC_W'(1);
			bytes_q <= bytes_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_single || cmd.emit_snap || cmd.emit_wr) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_single) begin
			out_data.status           <= pend_status_q;
			out_data.file_kind        <= pend_kind_q;
			out_data.file_index       <= pend_idx_q;
			out_data.selected_version <= pend_ver_q;
			out_data.selected_length  <= pend_len_q;
			out_data.delta_bytes      <= '0;
			out_data.included_version <= '1;
			out_data.last             <= 1'b1;
		end else if (cmd.emit_snap) begin
			out_data.status           <= ST_OK;
			out_data.file_kind        <= KIND_SNAP;
			out_data.file_index       <= IDX_W'(s_idx_q);
			out_data.selected_version <= s_ver_q;
			out_data.selected_length  <= LEN_W'(s_len_q);
			out_data.delta_bytes      <= '0;
			out_data.included_version <= {1'b0, s_ver_q};
			out_data.last             <= (cur_q == end_q);
		end else if (cmd.emit_wr) begin
			out_data.status           <= ST_OK;
			out_data.file_kind        <= KIND_DELTA;
			out_data.file_index       <= IDX_W'(cur_q);
			out_data.selected_version <= d_rd_ver;
			out_data.selected_length  <= LEN_W'(d_rd_len);
			out_data.delta_bytes      <= BYTES_W'(bytes_next);
			out_data.included_version <= {1'b0, d_rd_ver};
			out_data.last             <= stat.last_delta;
		end
	end

	assign out_valid = out_valid_q;

	// status to the controller
	assign stat.in_query   = (in_data.op == OP_QUERY);
	assign stat.need_snap  = need_snap;
	assign stat.scan_done  = !scan_go && !rv_s1;
	assign stat.have_snap  = have_snap_q;
	assign stat.empty      = (cur_q == end_q);
	assign stat.last_delta = ((cur_q + DC_W'(1)) == end_q);
	assign stat.out_free   = out_free;

	// checks
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_single || cmd.emit_snap || cmd.emit_wr) |-> out_free)
		else $error("result loaded over an untaken result");

	a_emit_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_wr |-> (cur_q < end_q))
		else $error("delta emission beyond selected range");

	a_end_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> (end_q <= delta_count_q))
		else $error("selected range exceeds delta table");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> ((snap_count_q <= SC_W'(SNAP_DEPTH)) &&
			(delta_count_q <= DC_W'(DELTA_DEPTH))))
		else $error("table count above depth");

endmodule

// ----- verif/tb_versioned_file_set_selector_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_versioned_file_set_selector_core
// Drives clear, append and query commands into the file set selector with
// random idle gaps on both channels, predicts the result stream from a
// local model of the snapshot and delta tables, and checks each result
// field by field in order.
// ----------------------------------------------------------------------------
import vfss_pkg::*;

// expected result store with a file table model
class file_set_board;
	logic [VER_W-1:0]   snap_ver [SNAP_DEPTH];
	logic [LEN_W-1:0]   snap_len [SNAP_DEPTH];
	logic [VER_W-1:0]   dlt_ver [DELTA_DEPTH];
	logic [LEN_W-1:0]   dlt_len [DELTA_DEPTH];
	int                 snap_cnt;
	int                 dlt_cnt;
	out_payload_t       pending_results[$];
	int                 errors;

	function new();
		snap_cnt = 0;
		dlt_cnt = 0;
		errors = 0;
	endfunction

	function void push(logic [STAT_W-1:0] st, logic [KIND_W-1:0] kind, int idx,
			logic [VER_W-1:0] ver, logic [LEN_W-1:0] len, logic [BYTES_W-1:0] bytes,
			logic signed [INCL_W-1:0] incl);
		out_payload_t r;
		r.status = st;
		r.file_kind = kind;
		r.file_index = idx[IDX_W-1:0];
		r.selected_version = ver;
		r.selected_length = len;
		r.delta_bytes = bytes;
		r.included_version = incl;
		r.last = 1'b0;
		pending_results.insert(pending_results.size(), r);
	endfunction

	function void seal();
		pending_results[pending_results.size()-1].last = 1'b1;
	endfunction

	function void append_file(bit is_snap, logic [VER_W-1:0] ver, logic [LEN_W-1:0] len);
		int n;
		n = is_snap ? snap_cnt : dlt_cnt;
		if (n >= (is_snap ? SNAP_DEPTH : DELTA_DEPTH)) begin
			push(ST_FULL, KIND_NONE, 0, '0, '0, '0, -1);
		end else if (n > 0 && (is_snap ? snap_ver[n-1] : dlt_ver[n-1]) >= ver) begin
			push(ST_ORDER, KIND_NONE, 0, '0, '0, '0, -1);
		end else begin
			if (is_snap) begin
				snap_ver[n] = ver;
				snap_len[n] = len;
				snap_cnt++;
			end else begin
				dlt_ver[n] = ver;
				dlt_len[n] = len;
				dlt_cnt++;
			end
			push(ST_OK, is_snap ? KIND_SNAP : KIND_DELTA, n, ver, len, '0, -1);
		end
	endfunction

	function void select_files(logic [VER_W-1:0] bv, logic [VER_W-1:0] rv, bit col, bit summ);
		bit have;
		int s, d, j, k;
		longint signed left;
		logic [BYTES_W-1:0] bytes;
		logic signed [INCL_W-1:0] incl;
		have = 0;
		s = 0;
		k = 0;
		bytes = '0;
		incl = -1;
		if (bv == 0 || col) begin
			for (int i = 0; i < snap_cnt; i++)
				if (snap_ver[i] <= rv) begin
					s = i;
					have = 1;
				end
			if (!have) begin
				push(ST_NOSNAP, KIND_NONE, 0, '0, '0, '0, -1);
				seal();
				return;
			end
		end
		d = 0;
		if (bv != 0) begin
			while (d < dlt_cnt && dlt_ver[d] < bv)
				d++;
			if (col) begin
				left = longint'(snap_len[s]);
				j = d;
				while (j < dlt_cnt && dlt_ver[j] <= snap_ver[s] && left > 0) begin
					left -= longint'(dlt_len[j]);
					j++;
				end
				if (left > 0) begin
					have = 0;
				end else begin
					d = 0;
					while (d < dlt_cnt && dlt_ver[d] <= snap_ver[s])
						d++;
				end
			end
		end else begin
			while (d < dlt_cnt && dlt_ver[d] <= snap_ver[s])
				d++;
		end
		if (have) begin
			incl = {1'b0, snap_ver[s]};
			push(ST_OK, KIND_SNAP, s, snap_ver[s], snap_len[s], '0, incl);
			k++;
		end
		while (d < dlt_cnt && dlt_ver[d] < rv) begin
			bytes += dlt_len[d];
			incl = {1'b0, dlt_ver[d]};
			push(ST_OK, KIND_DELTA, d, dlt_ver[d], dlt_len[d], bytes, incl);
			k++;
			d++;
		end
		if (d < dlt_cnt && ((!summ && incl < $signed({1'b0, rv})) ||
				(summ && dlt_ver[d] == rv))) begin
			bytes += dlt_len[d];
			incl = {1'b0, dlt_ver[d]};
			push(ST_OK, KIND_DELTA, d, dlt_ver[d], dlt_len[d], bytes, incl);
			k++;
		end
		if (k == 0)
			push(ST_OK, KIND_NONE, 0, '0, '0, '0, -1);
		seal();
	endfunction

	// note an accepted command
	function void note_command(in_payload_t c);
		logic [LEN_W-1:0] len;
		len = c.file_length & LEN_W'((64'd1 << LENGTH_BITS) - 64'd1);
		case (c.op)
			OP_CLEAR: begin
				snap_cnt = 0;
				dlt_cnt = 0;
				push(ST_OK, KIND_NONE, 0, '0, '0, '0, -1);
				seal();
			end
			OP_SNAP: begin
				append_file(1, c.file_version, len);
				seal();
			end
			OP_DELTA: begin
				append_file(0, c.file_version, len);
				seal();
			end
			default: select_files(c.begin_version, c.read_version, c.can_collapse,
				c.summarize);
		endcase
	endfunction

	// compare an accepted result with the oldest expectation
	function void check_result(out_payload_t got);
		out_payload_t exp_r;
		if (pending_results.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("unexpected result %p", got);
			return;
		end
		exp_r = pending_results.pop_front();
		if (got !== exp_r) begin
			errors++;
			if (errors <= 10)
				$display("result differs: expected %p actual %p", exp_r, got);
		end
	endfunction
endclass

module tb_versioned_file_set_selector_core;
	logic clk;
	logic arst_n;
	bit   quiet;
	int   idle_cycles = 0;
	int   stall_left = 0;
	logic [VER_W-1:0] next_snap_ver;
	logic [VER_W-1:0] next_dlt_ver;

	vfss_in_if  req();
	vfss_out_if rsp();

	file_set_board board;

	versioned_file_set_selector_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// result side: random stall bursts on ready, check each transfer
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready)
			board.check_result(rsp.data);
		if (!quiet && stall_left > 0) begin
			stall_left <= stall_left - 1;
			rsp.ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 8);
			rsp.ready <= 1'b0;
		end else begin
			stall_left <= 0;
			rsp.ready <= 1'b1;
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("versioned_file_set_selector_core: mismatch");
			$finish;
		end
	end

	task automatic send(in_payload_t c);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 9);
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.data <= c;
		req.valid <= 1'b1;
		do @(posedge clk); while (!req.ready);
		board.note_command(c);
	endtask

	function automatic logic [VER_W-1:0] rand_ver();
		return VER_W'({$urandom, $urandom});
	endfunction

	function automatic in_payload_t make_cmd(logic [OP_W-1:0] op, logic [VER_W-1:0] fv,
			logic [LEN_W-1:0] fl, logic [VER_W-1:0] bv, logic [VER_W-1:0] rv,
			bit col, bit summ);
		in_payload_t c;
		c.op = op;
		c.file_version = fv;
		c.file_length = fl;
		c.begin_version = bv;
		c.read_version = rv;
		c.can_collapse = col;
		c.summarize = summ;
		return c;
	endfunction

	// random table build, with occasional out-of-order versions, then queries near stored versions
	task automatic random_round();
		int n;
		logic [VER_W-1:0] rv, bv;
		logic [LEN_W-1:0] len;
		send(make_cmd(OP_CLEAR, rand_ver(), LEN_W'({$urandom, $urandom}), rand_ver(),
			rand_ver(), $urandom_range(0, 1), $urandom_range(0, 1)));
		next_snap_ver = VER_W'($urandom_range(0, 3));
		next_dlt_ver = VER_W'($urandom_range(0, 3));
		n = $urandom_range(2, 12);
		repeat (n) begin
			len = ($urandom_range(0, 7) == 0) ? LEN_W'({$urandom, $urandom}) :
				LEN_W'($urandom_range(0, 60));
			if ($urandom_range(0, 3) == 0) begin
				next_snap_ver += VER_W'($urandom_range(($urandom_range(0, 9) == 0) ? 0 : 1, 12));
				send(make_cmd(OP_SNAP, next_snap_ver, {len[LEN_W-1:8],
					8'($urandom_range(0, 120))}, rand_ver(), rand_ver(), 0, 0));
			end else begin
				next_dlt_ver += VER_W'($urandom_range(($urandom_range(0, 9) == 0) ? 0 : 1, 5));
				send(make_cmd(OP_DELTA, next_dlt_ver, len, rand_ver(), rand_ver(), 1, 1));
			end
		end
		repeat ($urandom_range(2, 5)) begin
			rv = VER_W'($urandom_range(0, 50));
			bv = ($urandom_range(0, 2) == 0) ? '0 : VER_W'($urandom_range(1, 50));
			if ($urandom_range(0, 5) == 0)
				rv = rand_ver();
			send(make_cmd(OP_QUERY, rand_ver(), LEN_W'({$urandom, $urandom}), bv, rv,
				$urandom_range(0, 1), $urandom_range(0, 1)));
		end
	endtask

	initial begin
		logic [VER_W-1:0] top;
		board = new();
		quiet = 1'b0;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.data = '0;
		top = '1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: errors, extremes, query special cases
		send(make_cmd(OP_QUERY, '0, '0, '0, top, 0, 0));
		send(make_cmd(OP_QUERY, '0, '0, 5, top, 0, 1));
		send(make_cmd(OP_SNAP, 10, 100, '0, '0, 0, 0));
		send(make_cmd(OP_SNAP, 10, 1, '0, '0, 0, 0));
		send(make_cmd(OP_DELTA, 0, '0, '0, '0, 0, 0));
		send(make_cmd(OP_DELTA, 4, 30, '0, '0, 0, 0));
		send(make_cmd(OP_DELTA, 12, 40, '0, '0, 0, 0));
		send(make_cmd(OP_DELTA, 15, '1, '0, '0, 0, 0));
		send(make_cmd(OP_DELTA, 20, 7, '0, '0, 0, 0));
		send(make_cmd(OP_QUERY, '0, '0, '0, 15, 0, 0));
		send(make_cmd(OP_QUERY, '0, '0, '0, 15, 0, 1));
		send(make_cmd(OP_QUERY, '0, '0, '0, 5, 0, 0));
		send(make_cmd(OP_QUERY, '0, '0, 1, 12, 1, 0));
		send(make_cmd(OP_QUERY, '0, '0, 12, 13, 1, 1));
		send(make_cmd(OP_QUERY, '0, '0, 13, 20, 0, 1));
		send(make_cmd(OP_QUERY, '0, '0, top, top, 0, 0));
		send(make_cmd(OP_SNAP, top, '1, top, top, 1, 1));
		send(make_cmd(OP_QUERY, '0, '0, '0, top, 1, 0));
		for (int i = 0; i < SNAP_DEPTH - 2; i++)
			send(make_cmd(OP_DELTA, 100 + i, i, '0, '0, 0, 0));
		send(make_cmd(OP_CLEAR, '0, '0, '0, '0, 0, 0));

		// fill both tables to overflow
		for (int i = 0; i <= DELTA_DEPTH; i++)
			send(make_cmd(OP_DELTA, i, i + 1, '0, '0, 0, 0));
		for (int i = 0; i <= SNAP_DEPTH; i++)
			send(make_cmd(OP_SNAP, 2 * i, 20, '0, '0, 0, 0));
		send(make_cmd(OP_QUERY, '0, '0, '0, top, 0, 0));
		send(make_cmd(OP_QUERY, '0, '0, 3, 31, 1, 1));

		// random rounds, the last ones without idling
		repeat (12)
			random_round();
		quiet = 1'b1;
		repeat (4)
			random_round();
		req.valid <= 1'b0;

		while (board.pending_results.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (board.errors == 0)
			$display("versioned_file_set_selector_core: match");
		else
			$display("versioned_file_set_selector_core: mismatch");
		$finish;
	end
endmodule
